/* src/adamu_pkg.sv */
`timescale 1ns / 1ps

package adamu_pkg;

  localparam int ENTRIES_DEFAULT = 4096;
  localparam int IDX_W = 12;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_BETA1 = 2'd0;
  localparam logic [1:0] REG_BETA2 = 2'd1;
  localparam logic [1:0] REG_LR    = 2'd2;
  localparam logic [1:0] REG_EPS   = 2'd3;

  localparam logic [15:0] BETA1_RESET = 16'd58982;
  localparam logic [15:0] BETA2_RESET = 16'd65470;
  localparam logic [23:0] LR_RESET    = 24'd16777;
  localparam logic [15:0] EPS_RESET   = 16'd1;

  localparam logic [31:0] POWER_ONE = 32'hFFFF_FFFF;
  localparam logic [39:0] MHAT_CAP  = 40'h7F_FFFF_FFFF;
  localparam logic [33:0] UPD_CAP   = 34'h2_0000_0000;

  typedef struct packed {
    logic               new_step;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] gradient;
    logic signed [31:0] weight;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   element;
    logic signed [31:0] new_weight;
  } result_t;

endpackage

/* src/adamu_ram.sv */
`timescale 1ns / 1ps

module adamu_ram #(
  parameter int W = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/adamu_div.sv */
`timescale 1ns / 1ps

module adamu_div #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 40,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int TW = NW - QW;
  localparam int CW = (TW > DW) ? TW : DW;

  logic          valid [QW+1];
  logic          over  [QW+1];
  logic [DW-1:0] rem   [QW+1];
  logic [QW-1:0] low   [QW+1];
  logic [QW-1:0] q     [QW+1];
  logic [DW-1:0] dv    [QW+1];
  logic [SW-1:0] side  [QW+1];
  logic [CW-1:0] top_ext;
  logic [CW-1:0] den_ext;

  assign top_ext = CW'(num[NW-1:QW]);
  assign den_ext = CW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      over[0] <= (top_ext >= den_ext);
      rem[0]  <= DW'(top_ext);
      low[0]  <= num[QW-1:0];
      q[0]    <= '0;
      dv[0]   <= den;
      side[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        take;

    assign shifted = {rem[k-1], low[k-1][QW-1]};
    assign take    = (shifted >= {1'b0, dv[k-1]});
    assign diff    = shifted - {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        over[k] <= over[k-1];
        rem[k]  <= take ? diff[DW-1:0] : shifted[DW-1:0];
        low[k]  <= {low[k-1][QW-2:0], 1'b0};
        q[k]    <= {q[k-1][QW-2:0], take};
        dv[k]   <= dv[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = valid[QW];
  assign quo       = q[QW];
  assign ovf       = over[QW];
  assign side_out  = side[QW];

endmodule

/* src/adamu_sqrt.sv */
`timescale 1ns / 1ps

module adamu_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   x,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [SW-1:0] side_out
);

  localparam int STEPS = 32;

  logic          valid [STEPS+1];
  logic [33:0]   rem   [STEPS+1];
  logic [31:0]   rt    [STEPS+1];
  logic [63:0]   rest  [STEPS+1];
  logic [SW-1:0] side  [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      rt[0]   <= '0;
      rest[0] <= x;
      side[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_stage
    logic [35:0] shifted;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        take;

    assign shifted = {rem[k-1], rest[k-1][63:62]};
    assign trial   = {2'b00, rt[k-1], 2'b01};
    assign take    = (shifted >= trial);
    assign diff    = shifted - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? diff[33:0] : shifted[33:0];
        rt[k]   <= {rt[k-1][30:0], take};
        rest[k] <= {rest[k-1][61:0], 2'b00};
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = valid[STEPS];
  assign root      = rt[STEPS];
  assign side_out  = side[STEPS];

endmodule

/* src/adam_optimizer_update.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake                     Word
// item     in   item_valid / item_stall       new_step, index, gradient, weight
// result   out  result_valid / result_stall   element, new_weight
// config   in   psel, penable, pwrite, pready beta1, beta2, learning_rate, epsilon
//
// One word is accepted per cycle while item_stall is low; the pipeline depth is set by
// the three divide pipelines and the square root, each resolving one bit per stage.
// After reset both moment memories are cleared one entry per cycle, entry 0 to ENTRIES-1,
// and item_stall stays high during that pass.
// A stalled result holds; one more word lands in a skid register, then the pipeline halts.

module adam_optimizer_update #(
  parameter int ENTRIES = adamu_pkg::ENTRIES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  adamu_pkg::item_t                   item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output adamu_pkg::result_t                 result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [adamu_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import adamu_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  typedef struct packed {
    logic [47:0]      v;
    logic [32:0]      bc2;
    logic             neg;
    logic [31:0]      w;
    logic [IDX_W-1:0] idx;
  } a_side_t;

  typedef struct packed {
    logic [38:0]      mhat;
    logic             neg;
    logic [31:0]      w;
    logic [IDX_W-1:0] idx;
  } b_side_t;

  typedef struct packed {
    logic             neg;
    logic [31:0]      w;
    logic [IDX_W-1:0] idx;
  } c_side_t;

  logic [15:0] beta1;
  logic [15:0] beta2;
  logic [23:0] learning_rate;
  logic [15:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta1         <= BETA1_RESET;
      beta2         <= BETA2_RESET;
      learning_rate <= LR_RESET;
      epsilon       <= EPS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BETA1: beta1 <= pwdata[15:0];
        REG_BETA2: beta2 <= pwdata[15:0];
        REG_LR:    learning_rate <= pwdata[23:0];
        REG_EPS:   epsilon <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BETA1: prdata = {16'd0, beta1};
      REG_BETA2: prdata = {16'd0, beta2};
      REG_LR:    prdata = {8'd0, learning_rate};
      REG_EPS:   prdata = {16'd0, epsilon};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          skid_valid;
  logic          en;
  logic          accept;

  assign en         = !skid_valid;
  assign item_stall = clearing || skid_valid;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Input register.
  logic  p0_valid;
  item_t p0;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (en) begin
      p0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= item;
    end
  end

  // Slot, squared gradient, gradient term of the first moment and beta powers.
  logic [AW-1:0] p0_slot;

  if (ENTRIES >= (1 << IDX_W)) begin : g_slot_direct
    assign p0_slot = AW'(p0.index);
  end else begin : g_slot_mod
    localparam logic [24:0] RECIP = 25'((32'd1 << 24) / ENTRIES + 1);
    logic [36:0]        qprod;
    logic [12:0]        q_est;
    logic [23:0]        qe_mul;
    logic signed [24:0] rdiff;
    logic signed [24:0] rfix;

    assign qprod   = 37'(p0.index) * 37'(RECIP);
    assign q_est   = qprod[36:24];
    assign qe_mul  = 24'(q_est) * 24'(ENTRIES);
    assign rdiff   = $signed({13'd0, p0.index}) - $signed({1'b0, qe_mul});
    assign rfix    = rdiff + 25'(ENTRIES);
    assign p0_slot = rdiff[24] ? AW'(rfix) : AW'(rdiff);
  end

  logic [31:0]        graw;
  logic [31:0]        gmag;
  logic [63:0]        gsq_full;
  logic [16:0]        omb1;
  logic [16:0]        omb2;
  logic signed [49:0] gterm1;
  logic [31:0]        beta1_power;
  logic [31:0]        beta2_power;
  logic [31:0]        beta1_power_next;
  logic [31:0]        beta2_power_next;
  logic [47:0]        pprod1;
  logic [47:0]        pprod2;

  assign graw     = p0.gradient;
  assign gmag     = graw[31] ? (32'd0 - graw) : graw;
  assign gsq_full = 64'(gmag) * 64'(gmag);
  assign omb1     = 17'h1_0000 - 17'(beta1);
  assign omb2     = 17'h1_0000 - 17'(beta2);
  assign gterm1   = $signed({{18{graw[31]}}, graw}) * $signed({33'd0, omb1});
  assign pprod1   = 48'(beta1_power) * 48'(beta1);
  assign pprod2   = 48'(beta2_power) * 48'(beta2);
  assign beta1_power_next = p0.new_step ? pprod1[47:16] : beta1_power;
  assign beta2_power_next = p0.new_step ? pprod2[47:16] : beta2_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta1_power <= POWER_ONE;
      beta2_power <= POWER_ONE;
    end else if (en && p0_valid) begin
      beta1_power <= beta1_power_next;
      beta2_power <= beta2_power_next;
    end
  end

  logic               p1_valid;
  logic [AW-1:0]      p1_slot;
  logic [46:0]        p1_gsq;
  logic signed [49:0] p1_gterm1;
  logic [32:0]        p1_bc1;
  logic [32:0]        p1_bc2;
  logic [31:0]        p1_w;
  logic [IDX_W-1:0]   p1_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_slot   <= p0_slot;
      p1_gsq    <= gsq_full[62:16];
      p1_gterm1 <= gterm1;
      p1_bc1    <= 33'h1_0000_0000 - 33'(beta1_power_next);
      p1_bc2    <= 33'h1_0000_0000 - 33'(beta2_power_next);
      p1_w      <= p0.weight;
      p1_idx    <= p0.index;
    end
  end

  // Gradient term of the second moment; the moment memories are read here.
  logic               p2_valid;
  logic [AW-1:0]      p2_slot;
  logic signed [49:0] p2_gterm1;
  logic [63:0]        p2_gterm2;
  logic [32:0]        p2_bc1;
  logic [32:0]        p2_bc2;
  logic [31:0]        p2_w;
  logic [IDX_W-1:0]   p2_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_slot   <= p1_slot;
      p2_gterm1 <= p1_gterm1;
      p2_gterm2 <= 64'(p1_gsq) * 64'(omb2);
      p2_bc1    <= p1_bc1;
      p2_bc2    <= p1_bc2;
      p2_w      <= p1_w;
      p2_idx    <= p1_idx;
    end
  end

  logic               p3_valid;
  logic [AW-1:0]      p3_slot;
  logic signed [49:0] p3_gterm1;
  logic [63:0]        p3_gterm2;
  logic [32:0]        p3_bc1;
  logic [32:0]        p3_bc2;
  logic [31:0]        p3_w;
  logic [IDX_W-1:0]   p3_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_slot   <= p2_slot;
      p3_gterm1 <= p2_gterm1;
      p3_gterm2 <= p2_gterm2;
      p3_bc1    <= p2_bc1;
      p3_bc2    <= p2_bc2;
      p3_w      <= p2_w;
      p3_idx    <= p2_idx;
    end
  end

  // Moment update with forwarding of the most recent write.
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic          mem_we;
  logic [31:0]   m_rd;
  logic [47:0]   v_rd;
  logic [31:0]   m_wdata;
  logic [47:0]   v_wdata;
  logic          last_valid;
  logic [AW-1:0] last_slot;
  logic [31:0]   last_m;
  logic [47:0]   last_v;
  logic          fwd;
  logic [31:0]   m_old;
  logic [47:0]   v_old;
  logic signed [49:0] mprod;
  logic signed [49:0] msum;
  logic [63:0]   vsum;
  logic [31:0]   m_new;
  logic [47:0]   v_new;

  assign mem_raddr = en ? p2_slot : p3_slot;
  assign fwd       = last_valid && (last_slot == p3_slot);
  assign m_old     = fwd ? last_m : m_rd;
  assign v_old     = fwd ? last_v : v_rd;
  assign mprod     = $signed({{18{m_old[31]}}, m_old}) * $signed({34'd0, beta1});
  assign msum      = mprod + p3_gterm1;
  assign m_new     = msum[47:16];
  assign vsum      = 64'(v_old) * 64'(beta2) + p3_gterm2;
  assign v_new     = vsum[63:16];

  assign mem_we    = clearing || (en && p3_valid);
  assign mem_waddr = clearing ? clr_addr : p3_slot;
  assign m_wdata   = clearing ? 32'd0 : m_new;
  assign v_wdata   = clearing ? 48'd0 : v_new;

  adamu_ram #(.W(32), .DEPTH(ENTRIES)) u_first_moment (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (m_wdata),
    .raddr (mem_raddr),
    .rdata (m_rd)
  );

  adamu_ram #(.W(48), .DEPTH(ENTRIES)) u_second_moment (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (v_wdata),
    .raddr (mem_raddr),
    .rdata (v_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (en && p3_valid) begin
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p3_valid) begin
      last_slot <= p3_slot;
      last_m    <= m_new;
      last_v    <= v_new;
    end
  end

  logic             p4_valid;
  logic [31:0]      p4_m;
  logic [47:0]      p4_v;
  logic [32:0]      p4_bc1;
  logic [32:0]      p4_bc2;
  logic [31:0]      p4_w;
  logic [IDX_W-1:0] p4_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (en) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_m   <= m_new;
      p4_v   <= v_new;
      p4_bc1 <= p3_bc1;
      p4_bc2 <= p3_bc2;
      p4_w   <= p3_w;
      p4_idx <= p3_idx;
    end
  end

  // Bias-corrected first moment.
  logic [31:0] mmag;
  a_side_t     a_in;
  a_side_t     a_out;
  logic        a_valid;
  logic [39:0] a_q;
  logic        a_ovf;
  logic [39:0] mhat;

  assign mmag      = p4_m[31] ? (32'd0 - p4_m) : p4_m;
  assign a_in.v    = p4_v;
  assign a_in.bc2  = p4_bc2;
  assign a_in.neg  = p4_m[31];
  assign a_in.w    = p4_w;
  assign a_in.idx  = p4_idx;

  adamu_div #(.NW(64), .DW(33), .QW(40), .SW($bits(a_side_t))) u_div_mhat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p4_valid),
    .num       ({mmag, 32'd0}),
    .den       (p4_bc1),
    .side_in   (a_in),
    .out_valid (a_valid),
    .quo       (a_q),
    .ovf       (a_ovf),
    .side_out  (a_out)
  );

  assign mhat = (a_ovf || (a_q > MHAT_CAP)) ? MHAT_CAP : a_q;

  // Bias-corrected second moment.
  b_side_t     b_in;
  b_side_t     b_out;
  logic        b_valid;
  logic [63:0] b_q;
  logic        b_ovf;
  logic [63:0] vhat;

  assign b_in.mhat = mhat[38:0];
  assign b_in.neg  = a_out.neg;
  assign b_in.w    = a_out.w;
  assign b_in.idx  = a_out.idx;

  adamu_div #(.NW(80), .DW(33), .QW(64), .SW($bits(b_side_t))) u_div_vhat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .num       ({a_out.v, 32'd0}),
    .den       (a_out.bc2),
    .side_in   (b_in),
    .out_valid (b_valid),
    .quo       (b_q),
    .ovf       (b_ovf),
    .side_out  (b_out)
  );

  assign vhat = b_ovf ? '1 : b_q;

  logic        s_valid;
  logic [31:0] s_root;
  b_side_t     s_out;

  adamu_sqrt #(.SW($bits(b_side_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .x         (vhat),
    .side_in   (b_out),
    .out_valid (s_valid),
    .root      (s_root),
    .side_out  (s_out)
  );

  // Denominator and numerator of the step.
  logic             p5_valid;
  logic [40:0]      p5_denom;
  logic [62:0]      p5_prod;
  c_side_t          p5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else if (en) begin
      p5_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_denom     <= ((s_root == 32'd0) && (epsilon == 16'd0)) ? 41'd1 :
                      (41'({s_root, 8'd0}) + 41'(epsilon));
      p5_prod      <= 63'(s_out.mhat) * 63'(learning_rate);
      p5_side.neg  <= s_out.neg;
      p5_side.w    <= s_out.w;
      p5_side.idx  <= s_out.idx;
    end
  end

  c_side_t     c_out;
  logic        c_valid;
  logic [33:0] c_q;
  logic        c_ovf;
  logic [33:0] upd;

  adamu_div #(.NW(63), .DW(41), .QW(34), .SW($bits(c_side_t))) u_div_step (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p5_valid),
    .num       (p5_prod),
    .den       (p5_denom),
    .side_in   (p5_side),
    .out_valid (c_valid),
    .quo       (c_q),
    .ovf       (c_ovf),
    .side_out  (c_out)
  );

  assign upd = (c_ovf || (c_q > UPD_CAP)) ? UPD_CAP : c_q;

  logic signed [35:0] wext;
  logic signed [35:0] uext;
  logic signed [35:0] nsum;
  result_t            final_word;

  assign wext = $signed({{4{c_out.w[31]}}, c_out.w});
  assign uext = $signed({2'b00, upd});
  assign nsum = c_out.neg ? (wext + uext) : (wext - uext);

  always_comb begin
    final_word.element = c_out.idx;
    if (nsum > 36'sd2147483647) begin
      final_word.new_weight = 32'sh7FFF_FFFF;
    end else if (nsum < -36'sd2147483648) begin
      final_word.new_weight = 32'sh8000_0000;
    end else begin
      final_word.new_weight = nsum[31:0];
    end
  end

  // Output register with one skid entry.
  result_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && result_stall) begin
      if (!skid_valid && c_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else begin
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_stall) begin
      if (!skid_valid) begin
        skid <= final_word;
      end
    end else if (skid_valid) begin
      result <= skid;
    end else begin
      result <= final_word;
    end
  end

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("Skid register filled without a stalled result.");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!p0_valid && !p3_valid && !last_valid))
    else $error("Pipeline holds a word while the moment memories are cleared.");

  a_clear_span: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_addr) == LAST_ADDR))
    else $error("Clearing pass ended before the last entry.");

endmodule

/* bench/adam_update_checker.sv */
`timescale 1ns / 1ps

module adam_update_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  adamu_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  adamu_pkg::result_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  import adamu_pkg::*;

  localparam int DEPTH = 4096;

  logic [15:0] beta1_q, beta2_q, eps_q;
  logic [23:0] lr_q;
  logic signed [31:0] m_store [DEPTH];
  logic [47:0] v_store [DEPTH];
  logic [31:0] pow1, pow2;
  result_t expected_words [$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic update_element(input item_t it);
    logic signed [63:0] g, w, m, nw, macc;
    logic [63:0] gmag, g2, v, bc1, bc2, mmag, mhat, q, vhat, root, denom, upd;
    logic [11:0] slot;
    logic [127:0] prod;
    result_t r;
    slot = it.index;
    g = it.gradient;
    w = it.weight;
    if (it.new_step) begin
      pow1 = 32'((64'(pow1) * beta1_q) >> 16);
      pow2 = 32'((64'(pow2) * beta2_q) >> 16);
    end
    macc = 64'(m_store[slot]) * $signed({48'd0, beta1_q})
         + g * $signed(64'(65536 - beta1_q));
    m = macc >>> 16;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    m_store[slot] = m[31:0];
    gmag = (g < 0) ? -g : g;
    g2 = (gmag * gmag) >> 16;
    v = (64'(v_store[slot]) * beta2_q + g2 * 64'(65536 - beta2_q)) >> 16;
    v &= 64'hFFFF_FFFF_FFFF;
    v_store[slot] = v[47:0];
    bc1 = 64'h1_0000_0000 - pow1;
    bc2 = 64'h1_0000_0000 - pow2;
    mmag = (m < 0) ? -m : m;
    mhat = (mmag << 32) / bc1;
    if (mhat > 64'(MHAT_CAP)) mhat = 64'(MHAT_CAP);
    q = v / bc2;
    if (q >= 64'h1_0000_0000) vhat = '1;
    else vhat = (q << 32) + (((v % bc2) << 32) / bc2);
    root = int_sqrt(vhat);
    denom = (root << 8) + eps_q;
    if (denom == 0) denom = 1;
    prod = 128'(mhat) * lr_q;
    upd = 64'(prod / denom);
    if (upd > 64'(UPD_CAP)) upd = 64'(UPD_CAP);
    nw = (m < 0) ? w + $signed(upd) : w - $signed(upd);
    if (nw > 64'sd2147483647) nw = 64'sd2147483647;
    if (nw < -64'sd2147483648) nw = -64'sd2147483648;
    r.element = it.index;
    r.new_weight = nw[31:0];
    expected_words.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      beta1_q <= BETA1_RESET;
      beta2_q <= BETA2_RESET;
      lr_q <= LR_RESET;
      eps_q <= EPS_RESET;
      pow1 = POWER_ONE;
      pow2 = POWER_ONE;
      for (int i = 0; i < DEPTH; i++) begin
        m_store[i] = 0;
        v_store[i] = 0;
      end
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BETA1: beta1_q <= pwdata[15:0];
          REG_BETA2: beta2_q <= pwdata[15:0];
          REG_LR:    lr_q <= pwdata[23:0];
          REG_EPS:   eps_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) update_element(item);
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: element %0d", result.element);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.element !== result.element) begin
            $error("element: expected %0d, got %0d", e.element, result.element);
            fail_count <= fail_count + 1;
          end else if (e.new_weight !== result.new_weight) begin
            $error("new_weight: expected %h, got %h", e.new_weight, result.new_weight);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_words.size();
  end
endmodule

/* bench/tb_adam_optimizer_update.sv */
`timescale 1ns / 1ps

module tb_adam_optimizer_update;
  import adamu_pkg::*;

  logic clk = 0, rst = 1;
  logic item_valid = 0, item_stall, result_valid, result_stall = 0;
  item_t item = '0;
  result_t result;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int fail_count, pending;
  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  adam_optimizer_update dut (.*);

  adam_update_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    result_stall <= ($urandom_range(99) < recv_stall);
    if (cycles > 3000000) begin
      $display("tb_adam_optimizer_update: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] r, input logic [31:0] val);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {r, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item <= it;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic item_t rand_word(input int bound);
    item_t it;
    int k;
    it.new_step = ($urandom_range(31) == 0);
    it.index = 12'($urandom_range(bound));
    k = $urandom_range(3);
    it.gradient = (k == 0) ? $urandom : (k == 1) ? 32'($signed($urandom_range(65535)) - 32768)
                : (k == 2) ? 32'(int'($urandom_range(2000000)) - 1000000) : 0;
    it.weight = $urandom;
    return it;
  endfunction

  initial begin
    item_t it;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    it = '{0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    send_word(it);
    it = '{0, 12'hFFF, 32'sh8000_0000, 32'sh8000_0000};
    send_word(it);
    it = '{1, 5, 32'sh0100_0000, 0};
    send_word(it);
    it = '{0, 6, 0, 32'sh1234_5678};
    send_word(it);
    it = '{1, 5, -32'sh0100_0000, 32'sh8000_0001};
    send_word(it);
    it = '{0, 7, 32'sh0000_0001, 32'sh7FFF_FFF0};
    send_word(it);
    it = '{1, 12'hAAA, 32'sh5555_5555, 32'shAAAA_AAAA};
    send_word(it);
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin write_reg(REG_BETA1, 0); write_reg(REG_BETA2, 0);
             write_reg(REG_LR, 24'hFFFFFF); write_reg(REG_EPS, 0); end
        1: begin write_reg(REG_BETA1, 16'hFFFF); write_reg(REG_BETA2, 16'hFFFF);
             write_reg(REG_LR, 0); write_reg(REG_EPS, 16'hFFFF); end
        2: begin write_reg(REG_BETA1, 58982); write_reg(REG_BETA2, 65470);
             write_reg(REG_LR, 16777); write_reg(REG_EPS, 1); end
        default: begin write_reg(REG_BETA1, $urandom); write_reg(REG_BETA2, $urandom);
             write_reg(REG_LR, $urandom); write_reg(REG_EPS, $urandom); end
      endcase
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 58; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 58; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      for (int n = 0; n < 250; n++) send_word(rand_word((n % 3 == 0) ? 4095 : 15));
    end
    drain();
    if (fail_count == 0) $display("tb_adam_optimizer_update: clean");
    else $display("tb_adam_optimizer_update: errors");
    $finish;
  end
endmodule

/* adam_optimizer_update.f */
src/adamu_pkg.sv
src/adamu_ram.sv
src/adamu_div.sv
src/adamu_sqrt.sv
src/adam_optimizer_update.sv
bench/adam_update_checker.sv
bench/tb_adam_optimizer_update.sv
